[hw/rtl/framed_packet_receiver_xor_check_macros.svh]
// Assertion macros shared by the checker files.
`ifndef FRAMED_PACKET_RECEIVER_XOR_CHECK_MACROS_SVH
`define FRAMED_PACKET_RECEIVER_XOR_CHECK_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FPRX_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FPRX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/fprx_pkg.sv]
// ----------------------------------------------------------------------------
// fprx_pkg
// Types and constants of the framed packet receiver with XOR check.
// ----------------------------------------------------------------------------
package fprx_pkg;

    typedef enum logic [4:0] {
        PH_WAIT = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_DATA = 5'b00100,
        PH_SUM  = 5'b01000,
        PH_END  = 5'b10000
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_DATA = 2'd1,
        EV_ACK  = 2'd2,
        EV_NAK  = 2'd3
    } event_t;

    localparam logic [7:0] REPLY_ACK      = 8'h06;
    localparam logic [7:0] REPLY_NAK      = 8'h15;
    localparam logic [7:0] START_CODE_RST = 8'h02;
    localparam logic [7:0] END_CODE_RST   = 8'h03;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE   = 2'd1;

    typedef struct packed {
        event_t     event_kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] reply_code;
    } result_t;

endpackage

[hw/rtl/fprx_ifs.sv]
// ----------------------------------------------------------------------------
// fprx channel interfaces
// Valid/ready channels for received bytes, results and register writes.
// ----------------------------------------------------------------------------
interface fprx_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fprx_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] reply_code;

    modport source (output valid, output event_kind, output payload_byte,
                    output payload_index, output reply_code, input ready);
    modport sink   (input valid, input event_kind, input payload_byte,
                    input payload_index, input reply_code, output ready);
endinterface

interface fprx_cfg_if import fprx_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [7:0]           data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hw/rtl/fprx_deframer.sv]
// ----------------------------------------------------------------------------
// fprx_deframer
// Frame state, length/count/XOR tracking and per-byte result decode.
// ----------------------------------------------------------------------------
module fprx_deframer import fprx_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data,
    input  logic                 accept,
    input  logic [7:0]           rx_byte,
    output result_t              result
);

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] xor_reg, xor_next;
    logic [7:0] start_code_reg;
    logic [7:0] end_code_reg;
    logic [7:0] cnt_inc;

    assign cnt_inc = cnt_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        cnt_next   = cnt_reg;
        xor_next   = xor_reg;
        result     = '0;
        result.event_kind = EV_NONE;
        unique case (phase_reg)
            PH_LEN:
            begin
                len_next   = rx_byte;
                cnt_next   = 8'd0;
                xor_next   = 8'd0;
                phase_next = (rx_byte == 8'd0) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                xor_next             = xor_reg ^ rx_byte;
                cnt_next             = cnt_inc;
                result.event_kind    = EV_DATA;
                result.payload_byte  = rx_byte;
                result.payload_index = cnt_reg;
                if (cnt_inc >= len_reg)
                begin
                    phase_next = PH_SUM;
                end
            end
            PH_SUM:
            begin
                if (rx_byte != xor_reg)
                begin
                    phase_next        = PH_WAIT;
                    result.event_kind = EV_NAK;
                    result.reply_code = REPLY_NAK;
                end
                else
                begin
                    phase_next = PH_END;
                end
            end
            PH_END:
            begin
                phase_next = PH_WAIT;
                if (rx_byte != end_code_reg)
                begin
                    result.event_kind = EV_NAK;
                    result.reply_code = REPLY_NAK;
                end
                else
                begin
                    result.event_kind = EV_ACK;
                    result.reply_code = REPLY_ACK;
                end
            end
            default:
            begin
                // waiting for start code
                if (rx_byte != start_code_reg)
                begin
                    phase_next        = PH_WAIT;
                    result.event_kind = EV_NAK;
                    result.reply_code = REPLY_NAK;
                end
                else
                begin
                    phase_next = PH_LEN;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            xor_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            xor_reg   <= xor_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= START_CODE_RST;
            end_code_reg   <= END_CODE_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_START_CODE)
            begin
                start_code_reg <= cfg_data;
            end
            else if (cfg_index == CFG_END_CODE)
            begin
                end_code_reg <= cfg_data;
            end
        end
    end

endmodule

[hw/rtl/fprx_out_stage.sv]
// ----------------------------------------------------------------------------
// fprx_out_stage
// Result register; refills in the same cycle the held item is taken.
// ----------------------------------------------------------------------------
module fprx_out_stage import fprx_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t d,
    input  logic    out_ready,
    output logic    out_valid,
    output result_t q,
    output logic    in_ready
);

    logic    valid_reg;
    result_t data_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign q         = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= d;
        end
    end

endmodule

[hw/rtl/framed_packet_receiver_xor_check.sv]
// ----------------------------------------------------------------------------
// framed_packet_receiver_xor_check
// Deframes start/length/payload/XOR/end packets from a byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   rx     : one received byte per item (valid/ready).
//   result : exactly one item per received byte: event kind, payload byte
//            and index for payload bytes, reply code 0x06/0x15 on ACK/NAK.
//   cfg    : register writes (index 0 start code, 1 end code); always ready,
//            other indexes are ignored. Write only while idle.
// Output: registered; a result is valid the cycle after its byte is accepted.
// Throughput: one byte per cycle while the result is not stalled; the frame
//   state updates per byte; the result register refills on the edge it drains.
// Stall: while result is held with ready low, rx.ready drops; the result
//   holds steady until taken.
// Reset: frame state returns to waiting for a start code, codes go to
//   0x02/0x03, the result register empties.
// Payload bytes are not buffered: a consumer drops them if the packet NAKs.
// ----------------------------------------------------------------------------
module framed_packet_receiver_xor_check import fprx_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    fprx_byte_if.sink rx,
    fprx_result_if.source result,
    fprx_cfg_if.sink  cfg
);

    logic    accept;
    result_t dec_result;
    result_t out_result;
    logic    out_valid;
    logic    in_ready;

    assign accept    = rx.valid && in_ready;
    assign rx.ready  = in_ready;
    assign cfg.ready = 1'b1;

    fprx_deframer u_deframer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .accept    (accept),
        .rx_byte   (rx.rx_byte),
        .result    (dec_result)
    );

    fprx_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .d         (dec_result),
        .out_ready (result.ready),
        .out_valid (out_valid),
        .q         (out_result),
        .in_ready  (in_ready)
    );

    assign result.valid         = out_valid;
    assign result.event_kind    = out_result.event_kind;
    assign result.payload_byte  = out_result.payload_byte;
    assign result.payload_index = out_result.payload_index;
    assign result.reply_code    = out_result.reply_code;

endmodule

[hw/rtl/fprx_checker.sv]
// ----------------------------------------------------------------------------
// fprx_port_checks
// Port-level checks of the framed packet receiver, bound to the top level.
// ----------------------------------------------------------------------------
`include "framed_packet_receiver_xor_check_macros.svh"

module fprx_port_checks import fprx_pkg::*; (
    input logic       clk,
    input logic       rst_n,
    input logic       rx_valid,
    input logic       rx_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic [1:0] event_kind,
    input logic [7:0] payload_byte,
    input logic [7:0] payload_index,
    input logic [7:0] reply_code
);

    logic [25:0] res_fields;
    logic        rx_take;
    logic        none_ok;
    logic        data_ok;
    logic        ack_ok;
    logic        nak_ok;
    logic        fields_ok;

    assign res_fields = {event_kind, payload_byte, payload_index, reply_code};
    assign rx_take    = rx_valid && rx_ready;

    assign none_ok = (event_kind == EV_NONE) && (reply_code == 8'h00)
                     && (payload_byte == 8'h00) && (payload_index == 8'h00);
    assign data_ok = (event_kind == EV_DATA) && (reply_code == 8'h00);
    assign ack_ok  = (event_kind == EV_ACK) && (reply_code == REPLY_ACK)
                     && (payload_byte == 8'h00);
    assign nak_ok  = (event_kind == EV_NAK) && (reply_code == REPLY_NAK)
                     && (payload_byte == 8'h00);
    assign fields_ok = none_ok || data_ok || ack_ok || nak_ok;

    // held result may not change or vanish under stall
    `FPRX_ASSERT_NEXT(a_hold, clk, rst_n, res_valid && !res_ready, res_valid && $stable(res_fields), "result changed while stalled")

    // a new result needs a byte accepted on the previous edge
    `FPRX_ASSERT(a_cause, clk, rst_n, res_valid && !$past(res_valid), $past(rx_take), "result without an accepted byte")

    // reply code and payload fields agree with the event kind
    `FPRX_ASSERT(a_fields, clk, rst_n, res_valid, fields_ok, "result fields inconsistent")

    // an empty result register always takes a byte
    `FPRX_ASSERT(a_ready, clk, rst_n, !res_valid, rx_ready, "input stalled with empty output")

endmodule

bind framed_packet_receiver_xor_check fprx_port_checks u_fprx_port_checks (
    .clk           (clk),
    .rst_n         (rst_n),
    .rx_valid      (rx.valid),
    .rx_ready      (rx.ready),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .event_kind    (result.event_kind),
    .payload_byte  (result.payload_byte),
    .payload_index (result.payload_index),
    .reply_code    (result.reply_code)
);

[tb/fprx_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fprx_checker
// Passive checker for the framed packet receiver. It follows the register
// writes, tracks the deframing state for every accepted byte and compares each
// accepted result, field by field, with the oldest predicted event.
// ----------------------------------------------------------------------------
module fprx_checker import fprx_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    fprx_byte_if   rx,
    fprx_result_if result,
    fprx_cfg_if    cfg,
    output int     fails,
    output int     pending
);

    logic [7:0] start_code;
    logic [7:0] end_code;
    phase_t     phase;
    logic [7:0] frame_len;
    logic [7:0] byte_count;
    logic [7:0] frame_xor;
    result_t    owed_events[$];
    result_t    oldest;

    task automatic report(input string field, input logic [7:0] got,
                          input logic [7:0] want);
        fails++;
        $display("%0t ns: %s is 0x%02h, predicted 0x%02h", $time, field, got, want);
    endtask

    // One byte through the deframer; returns the event it should produce.
    function automatic result_t deframe_byte(input logic [7:0] b);
        result_t ev;
        ev = '0;
        case (phase)
            PH_LEN:
            begin
                frame_len  = b;
                byte_count = 8'h00;
                frame_xor  = 8'h00;
                phase      = (b == 8'h00) ? PH_SUM : PH_DATA;
            end
            PH_DATA:
            begin
                ev.event_kind    = EV_DATA;
                ev.payload_byte  = b;
                ev.payload_index = byte_count;
                frame_xor        = frame_xor ^ b;
                byte_count       = byte_count + 8'd1;
                if (byte_count >= frame_len)
                    phase = PH_SUM;
            end
            PH_SUM:
            begin
                if (b != frame_xor)
                begin
                    phase         = PH_WAIT;
                    ev.event_kind = EV_NAK;
                    ev.reply_code = REPLY_NAK;
                end
                else
                    phase = PH_END;
            end
            PH_END:
            begin
                phase = PH_WAIT;
                if (b != end_code)
                begin
                    ev.event_kind = EV_NAK;
                    ev.reply_code = REPLY_NAK;
                end
                else
                begin
                    ev.event_kind = EV_ACK;
                    ev.reply_code = REPLY_ACK;
                end
            end
            default:
            begin
                if (b != start_code)
                begin
                    phase         = PH_WAIT;
                    ev.event_kind = EV_NAK;
                    ev.reply_code = REPLY_NAK;
                end
                else
                    phase = PH_LEN;
            end
        endcase
        return ev;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code = START_CODE_RST;
            end_code   = END_CODE_RST;
            phase      = PH_WAIT;
            frame_len  = 8'h00;
            byte_count = 8'h00;
            frame_xor  = 8'h00;
            fails      = 0;
            owed_events.delete();
        end
        else
        begin
            // results are matched before this edge's byte is predicted
            if (result.valid && result.ready)
            begin
                if (owed_events.size() == 0)
                    report("unpredicted result, event_kind",
                           {6'd0, result.event_kind}, 8'h00);
                else
                begin
                    oldest = owed_events.pop_front();
                    if (result.event_kind !== oldest.event_kind)
                        report("event_kind", {6'd0, result.event_kind},
                               {6'd0, oldest.event_kind});
                    if (result.payload_byte !== oldest.payload_byte)
                        report("payload_byte", result.payload_byte, oldest.payload_byte);
                    if (result.payload_index !== oldest.payload_index)
                        report("payload_index", result.payload_index, oldest.payload_index);
                    if (result.reply_code !== oldest.reply_code)
                        report("reply_code", result.reply_code, oldest.reply_code);
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_START_CODE)
                    start_code = cfg.data;
                else if (cfg.index == CFG_END_CODE)
                    end_code = cfg.data;
            end
            if (rx.valid && rx.ready)
                owed_events.push_back(deframe_byte(rx.rx_byte));
        end
        pending = owed_events.size();
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top of the framed packet receiver bench: drives bytes and register writes,
// stalls the result side, and reports the checker's verdict. A short directed
// run covers the framing corner cases; random packets, mostly well formed,
// follow under three idling patterns and several start/end code settings.
// ----------------------------------------------------------------------------
module tb;
    import fprx_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 250;

    typedef enum int {
        FLAW_NONE,
        FLAW_BAD_SUM,
        FLAW_BAD_END,
        FLAW_TRUNCATED
    } flaw_t;

    logic clk;
    logic rst_n;

    fprx_byte_if   rx_ch ();
    fprx_result_if res_ch ();
    fprx_cfg_if    cfg_ch ();

    int fails;
    int pending;
    int send_idle_pct = 29;
    int recv_idle_pct = 88;
    int hold_req      = 0;
    int hold_left     = 0;
    int cycles        = 0;
    int items_sent    = 0;

    logic [7:0] cur_start = START_CODE_RST;
    logic [7:0] cur_end   = END_CODE_RST;

    logic [7:0] opening[$] = '{
        8'h00, 8'hFF,                                   // wrong start bytes
        8'h02, 8'h03, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h03, // good packet
        8'h02, 8'h00, 8'h00, 8'h03,                     // zero length
        8'h02, 8'h01, 8'h55, 8'h54,                     // checksum mismatch
        8'h02, 8'h00, 8'h00, 8'hFF,                     // wrong end byte
        8'h02, 8'h01                                    // left open on purpose
    };

    framed_packet_receiver_xor_check u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .rx     (rx_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    fprx_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .result  (res_ch),
        .cfg     (cfg_ch),
        .fails   (fails),
        .pending (pending)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("framed_packet_receiver_xor_check: mismatch");
            $finish;
        end
    end

    // result side: random stalls, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else if (hold_left != 0)
        begin
            hold_left--;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_ch.ready);
        items_sent++;
    endtask

    // stop sending and let every predicted result come out
    task automatic drain();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_START_CODE)
            cur_start = value;
        else if (idx == CFG_END_CODE)
            cur_end = value;
    endtask

    task automatic send_packet(input int len, input flaw_t flaw);
        logic [7:0] sum;
        logic [7:0] b;
        int         n;
        sum = 8'h00;
        n   = (flaw == FLAW_TRUNCATED) ? $urandom_range(0, len) : len;
        send_byte(cur_start);
        send_byte(8'(len));
        for (int i = 0; i < n; i++)
        begin
            b   = 8'($urandom);
            sum = sum ^ b;
            send_byte(b);
        end
        if (flaw != FLAW_TRUNCATED)
        begin
            if (flaw == FLAW_BAD_SUM)
                send_byte(sum ^ 8'($urandom_range(1, 255)));
            else
                send_byte(sum);
            if (flaw == FLAW_BAD_END)
                send_byte(cur_end ^ 8'($urandom_range(1, 255)));
            else
                send_byte(cur_end);
        end
    endtask

    task automatic random_traffic(input int count);
        int stop_at;
        int r;
        int len;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99);
            // mostly short frames, now and then a long or a full-length one
            len = $urandom_range(99);
            if (len < 3)
                len = 255;
            else if (len < 10)
                len = $urandom_range(13, 254);
            else
                len = $urandom_range(0, 12);
            if (r < 80)
                send_packet(len, FLAW_NONE);
            else if (r < 85)
                send_byte(8'($urandom));
            else if (r < 90)
                send_packet(len, FLAW_BAD_SUM);
            else if (r < 95)
                send_packet(len, FLAW_BAD_END);
            else
                send_packet(len, FLAW_TRUNCATED);
        end
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= 8'h00;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_START_CODE;
        cfg_ch.data   <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening[i])
            send_byte(opening[i]);

        // frame is waiting on its payload byte: change the end code mid-packet
        drain();
        write_reg(CFG_END_CODE, 8'h7E);
        write_reg(CFG_SPARE_2, 8'hA5);
        write_reg(CFG_SPARE_3, 8'h5A);
        send_byte(8'h80);
        send_byte(8'h80);
        send_byte(8'h7E);

        drain();
        write_reg(CFG_START_CODE, 8'h00);
        write_reg(CFG_END_CODE, 8'hFF);
        random_traffic(PHASE_ITEMS);

        drain();
        write_reg(CFG_START_CODE, 8'hFF);
        write_reg(CFG_END_CODE, 8'h00);
        send_idle_pct = 88;
        recv_idle_pct = 29;
        random_traffic(PHASE_ITEMS);

        drain();
        write_reg(CFG_START_CODE, 8'($urandom));
        write_reg(CFG_END_CODE, 8'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 200;
        send_packet(255, FLAW_NONE);
        random_traffic(PHASE_ITEMS);

        drain();
        repeat (5) @(posedge clk);
        if (fails == 0)
            $display("framed_packet_receiver_xor_check: match");
        else
            $display("framed_packet_receiver_xor_check: mismatch");
        $finish;
    end

endmodule
